// ===== src/form_urlencoded_decoder_unit_defines.svh =====
// Assertion macros for the checker file of the form decoder.
`ifndef FORM_URLENCODED_DECODER_UNIT_DEFINES_SVH
`define FORM_URLENCODED_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while arst_n is low.
`define FUD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet while arst_n is low.
`define FUD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/fud_pkg.sv =====
// Types and constants shared by the form decoder files.
package fud_pkg;

	// Result kinds.
	localparam logic [2:0] KIND_NAME       = 3'd0;
	localparam logic [2:0] KIND_VALUE      = 3'd1;
	localparam logic [2:0] KIND_PAIR_END   = 3'd2;
	localparam logic [2:0] KIND_NAME_LONG  = 3'd3;
	localparam logic [2:0] KIND_VALUE_LONG = 3'd4;
	localparam logic [2:0] KIND_DONE       = 3'd5;

	// Input actions.
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_END  = 1'b1;

	// Configuration register indexes.
	localparam logic REG_NAME_LIMIT  = 1'b0;
	localparam logic REG_VALUE_LIMIT = 1'b1;

	// Register widths and reset values.
	localparam int NAME_LIM_W  = 8;
	localparam int VALUE_LIM_W = 21;
	localparam logic [NAME_LIM_W-1:0]  NAME_LIMIT_RST  = 8'd63;
	localparam logic [VALUE_LIM_W-1:0] VALUE_LIMIT_RST = 21'd65536;

	// Special bytes.
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Escape phases.
	localparam logic [1:0] ESC_NONE  = 2'd0;
	localparam logic [1:0] ESC_PCT   = 2'd1;
	localparam logic [1:0] ESC_DIGIT = 2'd2;

	// One output word.
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
	} word_t;

	// All words that one input item causes, oldest in slot 0.
	typedef struct packed {
		logic [1:0]      cnt;
		word_t [2:0]     w;
	} bundle_t;

endpackage

// ===== src/fud_if.sv =====
// Handshake channel interfaces for the form decoder input and result words.
interface fud_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] raw_byte;

	modport source(output valid, action, raw_byte, input ready);
	modport sink(input valid, action, raw_byte, output ready);
endinterface

interface fud_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] data;
	logic       last;

	modport source(output valid, kind, data, last, input ready);
	modport sink(input valid, kind, data, last, output ready);
endinterface

// ===== src/form_urlencoded_decoder_unit.sv =====
// Top level of the streaming form-urlencoded decoder.
// Takes one raw byte or end marker per cycle and updates the parse state in that same
// cycle; the result words of the input, up to three, go into a two-deep queue and
// leave one word per cycle while result.ready is high. A byte
// input yields at most one word, so a byte stream runs at one byte per cycle while
// results are taken; an end marker yields up to three words. The input stalls only
// when the result queue holds two inputs' worth of words. Limits are to be written
// through cfg_we, cfg_index and cfg_wdata only while the block is idle, which the
// block itself does not enforce; name_limit resets to 63 and value_limit to 65536.
module form_urlencoded_decoder_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	fud_in_if.sink                              item,
	fud_out_if.source                           result,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [fud_pkg::VALUE_LIM_W-1:0]     cfg_wdata
);

	logic [fud_pkg::NAME_LIM_W-1:0]   name_limit_q;
	logic [fud_pkg::VALUE_LIM_W-1:0]  value_limit_q;
	fud_pkg::bundle_t                 bundle;
	fud_pkg::bundle_t                 fifo_q [2];
	fud_pkg::bundle_t                 head;
	logic                             wr_ptr_q;
	logic                             rd_ptr_q;
	logic [1:0]                       count_q;
	logic [1:0]                       word_idx_q;
	logic                             take;
	logic                             push;
	logic                             word_take;
	logic                             pop;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_limit_q  <= fud_pkg::NAME_LIMIT_RST;
			value_limit_q <= fud_pkg::VALUE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fud_pkg::REG_NAME_LIMIT:  name_limit_q  <= cfg_wdata[fud_pkg::NAME_LIM_W-1:0];
				fud_pkg::REG_VALUE_LIMIT: value_limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign item.ready = (count_q != 2'd2);
	assign take       = item.valid && item.ready;

	fud_step u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.action      (item.action),
		.raw_byte    (item.raw_byte),
		.name_limit  (name_limit_q),
		.value_limit (value_limit_q),
		.bundle      (bundle)
	);

	// Result queue, one entry per input that yields words.
	assign push      = take && (bundle.cnt != 2'd0);
	assign head      = fifo_q[rd_ptr_q];
	assign word_take = result.valid && result.ready;
	assign pop       = word_take && result.last;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= 1'b0;
			rd_ptr_q   <= 1'b0;
			count_q    <= 2'd0;
			word_idx_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q   <= !rd_ptr_q;
				word_idx_q <= 2'd0;
			end else if (word_take) begin
				word_idx_q <= word_idx_q + 2'd1;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Word serializer.
	assign result.valid = (count_q != 2'd0);
	assign result.kind  = head.w[word_idx_q].kind;
	assign result.data  = head.w[word_idx_q].data;
	assign result.last  = (word_idx_q == head.cnt - 2'd1);

endmodule

// ===== src/fud_step.sv =====
// Parse state of the form decoder and the logic that turns one input word into its results.
module fud_step (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  take,
	input  logic                                  action,
	input  logic [7:0]                            raw_byte,
	input  logic [fud_pkg::NAME_LIM_W-1:0]        name_limit,
	input  logic [fud_pkg::VALUE_LIM_W-1:0]       value_limit,
	output fud_pkg::bundle_t                      bundle
);

	logic [1:0]                         esc_q;
	logic [3:0]                         high_q;
	logic                               in_value_q;
	logic                               pair_open_q;
	logic [fud_pkg::VALUE_LIM_W-1:0]    field_cnt_q;
	logic                               halted_q;

	logic [1:0]                         esc_d;
	logic [3:0]                         high_d;
	logic                               in_value_d;
	logic                               pair_open_d;
	logic [fud_pkg::VALUE_LIM_W-1:0]    field_cnt_d;
	logic                               halted_d;

	logic                               hex_ok;
	logic [3:0]                         hex_val;
	logic                               ch_req;
	logic [7:0]                         ch_byte;
	logic                               amp_hit;
	logic                               eq_open;
	logic [fud_pkg::VALUE_LIM_W-1:0]    lim;
	logic                               over;
	fud_pkg::word_t                     ch_word;

	// Hex digit decode, either case.
	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		if (raw_byte >= 8'h30 && raw_byte <= 8'h39) begin
			hex_val = 4'(raw_byte - 8'h30);
		end else if (raw_byte >= 8'h61 && raw_byte <= 8'h66) begin
			hex_val = 4'(raw_byte - 8'h57);
		end else if (raw_byte >= 8'h41 && raw_byte <= 8'h46) begin
			hex_val = 4'(raw_byte - 8'h37);
		end else begin
			hex_ok = 1'b0;
		end
	end

	// Decide whether this word decodes a character, and handle the separators.
	always_comb begin
		ch_req  = 1'b0;
		ch_byte = fud_pkg::CH_QUEST;
		amp_hit = 1'b0;
		eq_open = 1'b0;
		esc_d   = esc_q;
		high_d  = high_q;
		if (action == fud_pkg::ACT_END) begin
			ch_req = !halted_q && (esc_q != fud_pkg::ESC_NONE);
		end else if (!halted_q) begin
			unique case (esc_q)
				fud_pkg::ESC_PCT: begin
					if (hex_ok) begin
						high_d = hex_val;
						esc_d  = fud_pkg::ESC_DIGIT;
					end else begin
						esc_d  = fud_pkg::ESC_NONE;
						ch_req = 1'b1;
					end
				end
				fud_pkg::ESC_DIGIT: begin
					esc_d   = fud_pkg::ESC_NONE;
					ch_req  = 1'b1;
					ch_byte = hex_ok ? {high_q, hex_val} : fud_pkg::CH_QUEST;
				end
				default: begin
					esc_d = fud_pkg::ESC_NONE;
					if (raw_byte == fud_pkg::CH_PCT) begin
						esc_d = fud_pkg::ESC_PCT;
					end else if (raw_byte == fud_pkg::CH_PLUS) begin
						ch_req  = 1'b1;
						ch_byte = fud_pkg::CH_SPACE;
					end else if (raw_byte == fud_pkg::CH_AMP) begin
						amp_hit = 1'b1;
					end else if (raw_byte == fud_pkg::CH_EQ) begin
						if (in_value_q) begin
							ch_req  = 1'b1;
							ch_byte = fud_pkg::CH_EQ;
						end else begin
							eq_open = 1'b1;
						end
					end else begin
						ch_req  = 1'b1;
						ch_byte = raw_byte;
					end
				end
			endcase
		end
	end

	// Length check against the limit of the current field.
	assign lim  = in_value_q ? value_limit
		: {{(fud_pkg::VALUE_LIM_W-fud_pkg::NAME_LIM_W){1'b0}}, name_limit};
	assign over = (field_cnt_q >= lim);

	always_comb begin
		if (over) begin
			ch_word.kind = in_value_q ? fud_pkg::KIND_VALUE_LONG : fud_pkg::KIND_NAME_LONG;
			ch_word.data = 8'd0;
		end else begin
			ch_word.kind = in_value_q ? fud_pkg::KIND_VALUE : fud_pkg::KIND_NAME;
			ch_word.data = ch_byte;
		end
	end

	// Next state and the result words, appended in order.
	always_comb begin
		in_value_d  = in_value_q;
		pair_open_d = pair_open_q;
		field_cnt_d = field_cnt_q;
		halted_d    = halted_q;
		bundle      = '0;
		if (ch_req) begin
			bundle.w[0] = ch_word;
			bundle.cnt  = 2'd1;
			if (over) begin
				halted_d = 1'b1;
			end else begin
				field_cnt_d = field_cnt_q + 1'b1;
				pair_open_d = 1'b1;
			end
		end
		if (amp_hit) begin
			bundle.w[0].kind = fud_pkg::KIND_PAIR_END;
			bundle.cnt       = 2'd1;
			in_value_d       = 1'b0;
			pair_open_d      = 1'b0;
			field_cnt_d      = '0;
		end
		if (eq_open) begin
			in_value_d  = 1'b1;
			pair_open_d = 1'b1;
			field_cnt_d = '0;
		end
		if (action == fud_pkg::ACT_END) begin
			if (!halted_d && pair_open_d) begin
				bundle.w[bundle.cnt].kind = fud_pkg::KIND_PAIR_END;
				bundle.cnt                = bundle.cnt + 2'd1;
			end
			bundle.w[bundle.cnt].kind = fud_pkg::KIND_DONE;
			bundle.cnt                = bundle.cnt + 2'd1;
			in_value_d  = 1'b0;
			pair_open_d = 1'b0;
			field_cnt_d = '0;
			halted_d    = 1'b0;
		end
	end

	// Parse state registers; the end marker returns them to reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q       <= fud_pkg::ESC_NONE;
			high_q      <= '0;
			in_value_q  <= 1'b0;
			pair_open_q <= 1'b0;
			field_cnt_q <= '0;
			halted_q    <= 1'b0;
		end else if (take) begin
			esc_q       <= (action == fud_pkg::ACT_END) ? fud_pkg::ESC_NONE : esc_d;
			high_q      <= (action == fud_pkg::ACT_END) ? 4'd0 : high_d;
			in_value_q  <= in_value_d;
			pair_open_q <= pair_open_d;
			field_cnt_q <= field_cnt_d;
			halted_q    <= halted_d;
		end
	end

endmodule

// ===== src/fud_checker.sv =====
// Port-level checks for the form decoder and the bind that attaches them.
`include "form_urlencoded_decoder_unit_defines.svh"

module fud_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] out_kind,
	input logic [7:0] out_data,
	input logic       out_last
);

	`FUD_ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid, "result word dropped while stalled")
	`FUD_ASSERT_NOW(a_data_zero, out_valid && out_kind != fud_pkg::KIND_NAME && out_kind != fud_pkg::KIND_VALUE, out_data == 8'd0, "non-character word carries data")
	`FUD_ASSERT_NOW(a_done_last, out_valid && out_kind == fud_pkg::KIND_DONE, out_last, "done word is not the final word of its input")
	`FUD_ASSERT_NEXT(a_rest_ready, out_valid && out_ready && !out_last, out_valid, "gap inside the words of one input")

endmodule

bind form_urlencoded_decoder_unit fud_checker u_fud_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_kind  (result.kind),
	.out_data  (result.data),
	.out_last  (result.last)
);
